// ===== hdl/npc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg: shared constants and types for the nearest palette color block
// Field widths, fixed-point widths and the divider request/response structs.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int COLOR_W     = 24;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int HSV_W       = 16;
  localparam int DIST_W      = 34;
  localparam int NUM_W       = 27;  // dividend width (n * 65535 with n < 1530 fits in 27 bits)
  localparam int DEN_W       = 11;  // divisor width (6 * 255 fits in 11 bits)

  typedef struct packed {
    logic [HSV_W-1:0] h;
    logic [HSV_W-1:0] s;
    logic [HSV_W-1:0] v;
  } hsv_t;

  // Divider request and response
  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [HSV_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/nearest_palette_color_hsv_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_hsv_top: nearest palette color search in HSV space
// A write word (mode 0) loads one entry. A query word scans the entries in
// use for an exact match, reading and comparing each entry in turn; an exact
// hit ends the query there. Otherwise it converts the query and each entry in
// use to HSV on one shared 27-step serial divider (two divisions per color)
// and accumulates squared differences on one shared 17-bit squarer. Gray
// colors skip the hue division, black skips both. The result appears for one
// cycle with out_valid once busy drops; the receiver cannot stall, so it must
// take it.
// ----------------------------------------------------------------------------
module nearest_palette_color_hsv_top #(
  parameter int ENTRIES = npc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [npc_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [npc_pkg::COLOR_W-1:0]   in_color,
  output logic                          out_valid,
  output logic [npc_pkg::IDX_W-1:0]     out_nearest_index,
  output logic                          out_exact_match,
  input  logic                          cfg_we,
  input  logic [npc_pkg::CNT_W-1:0]     cfg_entry_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HW = npc_pkg::HSV_W;
  localparam int DSW = npc_pkg::DIST_W;
  localparam int NW = npc_pkg::NUM_W;
  localparam int LIM = (ENTRIES < 16) ? ENTRIES : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EXACT, S_ERD, S_MM, S_SDIV, S_SWAIT, S_HDIV, S_HWAIT,
    S_SQ_H, S_SQ_S, S_SQ_V, S_CMP, S_DONE
  } state_t;

  state_t state_r;

  logic [npc_pkg::COLOR_W-1:0] mem [ENTRIES];
  logic [npc_pkg::COLOR_W-1:0] rd_r;
  logic [npc_pkg::CNT_W-1:0]   ecnt_r, cnt_lim;
  logic [npc_pkg::CNT_W-1:0]   i_r;
  logic [npc_pkg::COLOR_W-1:0] q_r;
  logic                        is_q_r;  // converting the query itself
  npc_pkg::hsv_t               qh_r, eh_r;
  logic [7:0]                  mx_r, d_r;
  logic [10:0]                 n_r;
  logic [DSW-1:0]              acc_r, best_r;
  logic [npc_pkg::IDX_W-1:0]   best_i_r;
  logic [16:0]                 sqa_r;
  logic [33:0]                 sq_w;
  npc_pkg::div_req_t           dreq;
  npc_pkg::div_rsp_t           drsp;
  logic [7:0]                  cr, cg, cb, mx, mn;
  logic [npc_pkg::COLOR_W-1:0] cur;

  npc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Effective count
  always_comb begin
    cnt_lim = ecnt_r;
    if (cnt_lim == '0) cnt_lim = 5'd1;
    if (cnt_lim > 5'(LIM)) cnt_lim = 5'(LIM);
  end

  // Max/min of color being converted
  assign cur = is_q_r ? q_r : rd_r;
  assign cr = cur[7:0];
  assign cg = cur[15:8];
  assign cb = cur[23:16];
  always_comb begin
    mx = cr; mn = cr;
    if (cg > mx) mx = cg;
    if (cb > mx) mx = cb;
    if (cg < mn) mn = cg;
    if (cb < mn) mn = cb;
  end

  // Shared squarer on the current absolute difference
  assign sq_w = 34'(sqa_r) * 34'(sqa_r);

  // Divider launch; black needs no saturation division
  always_comb begin
    dreq = '0;
    if (state_r == S_SDIV && mx_r != 8'd0) begin
      dreq.go  = 1'b1;
      dreq.num = NW'(d_r) * NW'(65535);
      dreq.den = 11'(mx_r);
    end else if (state_r == S_HDIV) begin
      dreq.go  = 1'b1;
      dreq.num = NW'(n_r) * NW'(65535);
      dreq.den = 11'(d_r) * 11'd6;
    end
  end

  function automatic logic [16:0] absd(input logic [HW-1:0] a, input logic [HW-1:0] b);
    absd = (a > b) ? 17'(a - b) : 17'(b - a);
  endfunction

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (start && !busy && !in_mode && (32'(in_entry_index) < ENTRIES))
      mem[AW'(in_entry_index)] <= in_color;
    rd_r <= mem[AW'(i_r)];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ecnt_r    <= 5'd16;
      out_valid <= 1'b0;
      i_r       <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) ecnt_r <= cfg_entry_count;
      case (state_r)
        S_IDLE: begin
          if (start && in_mode) begin
            q_r   <= in_color;
            i_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EXACT;  // registered read
        S_EXACT: begin
          if (rd_r == q_r) begin
            out_nearest_index <= 4'(i_r);
            out_exact_match   <= 1'b1;
            state_r           <= S_DONE;
          end else if (i_r + 5'd1 >= cnt_lim) begin
            i_r     <= '0;
            is_q_r  <= 1'b1;
            state_r <= S_MM;
          end else begin
            i_r     <= i_r + 5'd1;
            state_r <= S_RD;
          end
        end
        S_ERD: state_r <= S_MM;  // registered read for the distance pass
        S_MM: begin
          mx_r <= mx;
          d_r  <= mx - mn;
          eh_r.v <= 16'(mx) * 16'd257;
          if (mx == cr)
            n_r <= 11'(cg) - 11'(cb) + ((cg < cb) ? 11'(mx - mn) * 11'd6 : 11'd0);
          else if (mx == cg)
            n_r <= 11'(cb) - 11'(cr) + 11'(mx - mn) * 11'd2;
          else
            n_r <= 11'(cr) - 11'(cg) + 11'(mx - mn) * 11'd4;
          state_r <= S_SDIV;
        end
        S_SDIV: begin
          if (mx_r == 8'd0) begin
            eh_r.s <= '0;
            eh_r.h <= '0;
            state_r <= S_CMP;
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: if (drsp.done) begin
          eh_r.s <= drsp.quo;
          state_r <= S_HDIV;
          if (d_r == 8'd0) begin
            eh_r.h  <= '0;
            state_r <= S_CMP;
          end
        end
        S_HDIV: state_r <= S_HWAIT;
        S_HWAIT: if (drsp.done) begin
          eh_r.h  <= drsp.quo;
          state_r <= S_CMP;
        end
        // S_CMP: route a finished conversion
        S_CMP: begin
          if (is_q_r) begin
            qh_r    <= eh_r;
            is_q_r  <= 1'b0;
            i_r     <= '0;
            state_r <= S_ERD;
          end else begin
            sqa_r   <= absd(qh_r.h, eh_r.h);
            acc_r   <= '0;
            state_r <= S_SQ_H;
          end
        end
        S_SQ_H: begin
          acc_r   <= DSW'(sq_w);
          sqa_r   <= absd(qh_r.s, eh_r.s);
          state_r <= S_SQ_S;
        end
        S_SQ_S: begin
          acc_r   <= acc_r + DSW'(sq_w);
          sqa_r   <= absd(qh_r.v, eh_r.v);
          state_r <= S_SQ_V;
        end
        S_SQ_V: begin
          if (i_r == '0 || (acc_r + DSW'(sq_w)) < best_r) begin
            best_r   <= acc_r + DSW'(sq_w);
            best_i_r <= 4'(i_r);
          end
          if (i_r + 5'd1 >= cnt_lim) begin
            out_nearest_index <= (i_r == '0 || (acc_r + DSW'(sq_w)) < best_r)
                                 ? 4'(i_r) : best_i_r;
            out_exact_match   <= 1'b0;
            state_r           <= S_DONE;
          end else begin
            i_r     <= i_r + 5'd1;
            state_r <= S_ERD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  a_valid_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (5'(out_nearest_index) < cnt_lim)) else $error("index out of range");

endmodule

// ===== hdl/npc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_div: restoring divider, one quotient bit per cycle
// Quotient truncated to 16 bits; callers guarantee it fits.
// ----------------------------------------------------------------------------
module npc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  npc_pkg::div_req_t req,
  output npc_pkg::div_rsp_t rsp
);

  localparam int NW = npc_pkg::NUM_W;
  localparam int DW = npc_pkg::DEN_W;

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // One shift-subtract step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    if (req.go) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 5'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt    = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r[npc_pkg::HSV_W-1:0];

  // done is a single pulse after a run
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider busy at done");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |=> busy_r) else $error("divider did not start");

endmodule

// ===== bench/tb_nearest_palette_color_hsv_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_hsv_top: testbench for the HSV nearest color search
// Loads the palette, runs directed and random queries and entry writes under
// several entry counts, predicts each result with an HSV distance model, and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_hsv_top;

  localparam int  IDX_W       = npc_pkg::IDX_W;
  localparam int  COLOR_W     = npc_pkg::COLOR_W;
  localparam int  CNT_W       = npc_pkg::CNT_W;
  localparam int  HSV_W       = npc_pkg::HSV_W;
  localparam int  MODE_WRITE  = 0;
  localparam int  MODE_QUERY  = 1;
  localparam int  PAL_SIZE    = 16;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             exact;
  } nearest_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [IDX_W-1:0]    in_entry_index;
  logic [COLOR_W-1:0]  in_color;
  logic                out_valid;
  logic [IDX_W-1:0]    out_nearest_index;
  logic                out_exact_match;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_entry_count;

  // model state
  logic [COLOR_W-1:0]  pal_model [PAL_SIZE];
  logic [CNT_W-1:0]    count_model;
  nearest_t            nearest_q [$];
  int                  mismatches;
  longint              cycles = 0;
  bit                  no_gaps;

  nearest_palette_color_hsv_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_entry_index(in_entry_index), .in_color(in_color),
    .out_valid(out_valid), .out_nearest_index(out_nearest_index),
    .out_exact_match(out_exact_match),
    .cfg_we(cfg_we), .cfg_entry_count(cfg_entry_count)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_palette_color_hsv_top verification failed");
      $finish;
    end
  end

  // RGB to 16-bit HSV fractions
  function automatic npc_pkg::hsv_t rgb_to_hsv(logic [COLOR_W-1:0] c);
    longint r, g, b, mx, mn, d, n;
    npc_pkg::hsv_t o;
    r = c[7:0]; g = c[15:8]; b = c[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    o.v = HSV_W'(mx * 257);
    o.s = (mx == 0) ? '0 : HSV_W'((d * 65535) / mx);
    if (d == 0) o.h = '0;
    else begin
      if (mx == r)      n = (g - b) + ((g < b) ? 6 * d : 0);
      else if (mx == g) n = (b - r) + 2 * d;
      else              n = (r - g) + 4 * d;
      o.h = HSV_W'((n * 65535) / (6 * d));
    end
    return o;
  endfunction

  function automatic longint unsigned hsv_dist(npc_pkg::hsv_t a, npc_pkg::hsv_t b);
    longint da, ds, dv;
    da = longint'(a.h) - longint'(b.h);
    ds = longint'(a.s) - longint'(b.s);
    dv = longint'(a.v) - longint'(b.v);
    return da * da + ds * ds + dv * dv;
  endfunction

  // exact match first, else lowest index with the smallest distance
  function automatic nearest_t find_nearest(logic [COLOR_W-1:0] c);
    int cnt;
    nearest_t res;
    npc_pkg::hsv_t qh;
    longint unsigned bd, dd;
    cnt = (count_model == 0) ? 1 : ((count_model > PAL_SIZE) ? PAL_SIZE : count_model);
    for (int i = 0; i < cnt; i++)
      if (pal_model[i] == c) begin
        res.idx = IDX_W'(i); res.exact = 1'b1;
        return res;
      end
    qh = rgb_to_hsv(c);
    res.idx = '0; res.exact = 1'b0;
    bd = hsv_dist(qh, rgb_to_hsv(pal_model[0]));
    for (int i = 1; i < cnt; i++) begin
      dd = hsv_dist(qh, rgb_to_hsv(pal_model[i]));
      if (dd < bd) begin
        bd = dd; res.idx = IDX_W'(i);
      end
    end
    return res;
  endfunction

  // result checker; outputs are stable at the falling edge
  always @(negedge clk) begin
    nearest_t e;
    if (rst_n && out_valid) begin
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: idx %0d exact %0b",
                   out_nearest_index, out_exact_match);
      end else begin
        e = nearest_q.pop_front();
        if (out_nearest_index !== e.idx || out_exact_match !== e.exact) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %0d exact %0b, got idx %0d exact %0b",
                     e.idx, e.exact, out_nearest_index, out_exact_match);
        end
      end
    end
  end

  // send one word, wait for it to be taken, then maybe idle
  task automatic send_word(int mode, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] c);
    bit taken;
    int r, gap;
    start          <= 1'b1;
    in_mode        <= mode[0];
    in_entry_index <= idx;
    in_color       <= c;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    if (mode == MODE_WRITE) pal_model[idx] = c;
    else nearest_q.push_back(find_nearest(c));
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until idle with nothing outstanding
  task automatic drain();
    bit idle;
    start <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    idle = 0;
    while (!idle) begin
      @(negedge clk);
      idle = !busy;
      @(posedge clk);
    end
  endtask

  task automatic set_count(logic [CNT_W-1:0] v);
    drain();
    cfg_we          <= 1'b1;
    cfg_entry_count <= v;
    @(posedge clk);
    cfg_we          <= 1'b0;
    count_model = v;
  endtask

  // color near a palette entry, channels nudged and clamped
  function automatic logic [COLOR_W-1:0] near_color(logic [COLOR_W-1:0] base);
    logic [COLOR_W-1:0] c;
    int v;
    for (int k = 0; k < 3; k++) begin
      v = int'(base[8*k +: 8]) + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      c[8*k +: 8] = 8'(v);
    end
    return c;
  endfunction

  task automatic test_load_palette();
    logic [COLOR_W-1:0] init [PAL_SIZE] = '{
      24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h808080,
      24'h4000FF, 24'h00FF40, 24'h40FF00, 24'hFF4000, 24'h0040FF, 24'h800000,
      24'h0000FF, 24'h123456, 24'hA5C3E7, 24'h010101};
    for (int i = 0; i < PAL_SIZE; i++) send_word(MODE_WRITE, IDX_W'(i), init[i]);
  endtask

  task automatic test_directed_queries();
    send_word(MODE_QUERY, 4'hF, 24'h0000FF);  // duplicate red: lowest index wins
    send_word(MODE_QUERY, 4'h0, 24'hFFFFFF);
    send_word(MODE_QUERY, 4'h0, 24'h000000);
    send_word(MODE_QUERY, 4'h5, 24'h0100FF);  // red with blue above green
    send_word(MODE_QUERY, 4'h0, 24'hFE00FF);  // hue near the top, no wrap
    send_word(MODE_QUERY, 4'h0, 24'h7F7F7F);
    send_word(MODE_QUERY, 4'h0, 24'h00FE00);
    send_word(MODE_WRITE, 4'hF, 24'hFFFFFF);  // last entry duplicates entry 1
    send_word(MODE_QUERY, 4'h0, 24'hFFFFFF);
    send_word(MODE_QUERY, 4'h0, 24'h020202);
  endtask

  task automatic test_count_extremes();
    logic [CNT_W-1:0] counts [5] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd7};
    foreach (counts[i]) begin
      set_count(counts[i]);
      send_word(MODE_QUERY, 4'h0, 24'hFFFFFF);
      send_word(MODE_QUERY, 4'h0, 24'h0000FF);
      send_word(MODE_QUERY, 4'h0, COLOR_W'($urandom_range(0, 24'hFFFFFF)));
    end
  endtask

  task automatic test_random_traffic();
    int r;
    for (int ph = 0; ph < 6; ph++) begin
      set_count(ph == 5 ? 5'd16 : CNT_W'($urandom_range(0, 31)));
      no_gaps = (ph == 2);
      for (int i = 0; i < 80; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35)
          send_word(MODE_WRITE, IDX_W'($urandom_range(0, 15)), COLOR_W'($urandom));
        else if (r < 55)
          send_word(MODE_QUERY, IDX_W'($urandom), pal_model[$urandom_range(0, 15)]);
        else if (r < 80)
          send_word(MODE_QUERY, IDX_W'($urandom),
                    near_color(pal_model[$urandom_range(0, 15)]));
        else
          send_word(MODE_QUERY, IDX_W'($urandom), COLOR_W'($urandom));
      end
      no_gaps = 0;
    end
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_mode = 1'b0; in_entry_index = '0;
    in_color = '0; cfg_we = 1'b0; cfg_entry_count = '0;
    mismatches = 0; no_gaps = 0; count_model = 5'd16;
    foreach (pal_model[i]) pal_model[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_palette();
    test_directed_queries();
    test_count_extremes();
    test_random_traffic();
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && nearest_q.size() == 0)
      $display("nearest_palette_color_hsv_top verification clean");
    else
      $display("nearest_palette_color_hsv_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/npc_pkg.sv
hdl/npc_div.sv
hdl/nearest_palette_color_hsv_top.sv
bench/tb_nearest_palette_color_hsv_top.sv
